[design/wbps_pkg.sv]
// Shared types and constants of the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

  // Defaults for the top-level parameters
  localparam int PATTERN_MAX_DEFAULT = 128;
  localparam int OFFSET_BITS_DEFAULT = 32;

  // Field widths
  localparam int ENTRY_INDEX_W    = 7;
  localparam int BYTE_W           = 8;
  localparam int PATTERN_LENGTH_W = 8;
  localparam int ADDR_W           = 64;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_BASE      = 1'd1;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  // Strobes from the top level to the match core
  typedef struct packed {
    logic load;   // write one pattern entry
    logic scan;   // advance the match vector by one byte
    logic clear;  // end of scan: drop all partial matches
  } core_ctrl_t;

endpackage

[design/wbps_req_if.sv]
// Request channel: pattern loads and scanned buffer bytes.
`timescale 1ns / 1ps

interface wbps_req_if import wbps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [ENTRY_INDEX_W-1:0] entry_index;
  logic [BYTE_W-1:0]        pattern_byte;
  logic                     wildcard_req;
  logic [BYTE_W-1:0]        data_byte;
  logic                     last_byte;

  modport source (
    output valid, cmd, entry_index, pattern_byte, wildcard_req, data_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, pattern_byte, wildcard_req, data_byte, last_byte,
    output ready
  );
endinterface

[design/wbps_rsp_if.sv]
// Result channel: one match report per scan.
`timescale 1ns / 1ps

interface wbps_rsp_if import wbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;

  modport source (
    output valid, found, match_address,
    input  ready
  );
  modport sink (
    input  valid, found, match_address,
    output ready
  );
endinterface

[design/wbps_match_core.sv]
// Pattern storage and bit-parallel shift-and match vector.
`timescale 1ns / 1ps

module wbps_match_core import wbps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
  parameter int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  core_ctrl_t               ctrl,
  input  logic [ENTRY_INDEX_W-1:0] load_index,
  input  logic [BYTE_W-1:0]        load_byte,
  input  logic                     load_wild,
  input  logic [BYTE_W-1:0]        data_byte,
  input  logic [IDX_W-1:0]         lenm1,
  output logic                     hit
);

  logic [BYTE_W-1:0]      pattern_store [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] wildcard_store;
  logic [PATTERN_MAX-1:0] partial_match;
  logic [PATTERN_MAX-1:0] partial_match_next;

  // Entries are plain flops, every one read in parallel; an index past the
  // end never decodes, so such loads drop out.
  always_ff @(posedge clk) begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (ctrl.load && (32'(load_index) == k)) begin
        pattern_store[k]  <= load_byte;
        wildcard_store[k] <= load_wild;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      partial_match_next[k] = ((k == 0) ? 1'b1 : partial_match[(k > 0) ? k - 1 : 0]) &
                              (wildcard_store[k] | (pattern_store[k] == data_byte));
    end
  end

  assign hit = partial_match_next[lenm1];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      partial_match <= '0;
    end else if (ctrl.scan) begin
      partial_match <= partial_match_next;
    end
  end

endmodule

[design/wildcard_byte_pattern_scanner.sv]
// Top level of the wildcard byte pattern scanner.
`timescale 1ns / 1ps

// Usage
// - Configure pattern_length and scan_base through cfg_we/cfg_index/cfg_data
//   while the block is idle. Lengths of zero act as one; lengths above
//   PATTERN_MAX saturate.
// - req carries one transaction per item: cmd = load writes pattern entry
//   entry_index (byte or wildcard); cmd = scan feeds one buffer byte, with
//   last_byte on the final byte of the buffer.
// - rsp gives one transaction per scan: found = 1 with scan_base plus start
//   offset at the first full match, or found = 0 at the last byte. Bytes after
//   a match are swallowed up to and including last_byte.
// Timing
// - One item per cycle sustained. An item is held in the input register,
//   where the whole match vector updates at once; its result then goes to
//   the output register, which drives rsp.valid.
// - Stalls: while a result waits and rsp.ready is low, only an item that would
//   produce another result is held; loads and non-reporting bytes keep flowing.
// Reset (rst, synchronous): clears the match vector, offset and report flag,
// sets pattern_length to 1 and scan_base to 0. Pattern entries are not cleared
// and must be loaded before use.
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  wbps_req_if.sink               req,
  wbps_rsp_if.source             rsp
);

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  // Subtraction width: wide enough for both operands, truncated after
  localparam int SUB_W = (OFFSET_BITS > IDX_W) ? OFFSET_BITS : IDX_W;

  // ---------------- configuration ----------------
  logic [IDX_W-1:0]  lenm1;      // saturated pattern length minus one
  logic [IDX_W-1:0]  lenm1_next;
  logic [ADDR_W-1:0] scan_base;

  logic [PATTERN_LENGTH_W-1:0] cfg_len;
  assign cfg_len = cfg_data[PATTERN_LENGTH_W-1:0];

  always_comb begin
    if (cfg_len == '0) begin
      lenm1_next = '0;
    end else if (32'(cfg_len) > PATTERN_MAX) begin
      lenm1_next = IDX_W'(PATTERN_MAX - 1);
    end else begin
      lenm1_next = IDX_W'(cfg_len - PATTERN_LENGTH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lenm1     <= '0;
      scan_base <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: lenm1     <= lenm1_next;
        REG_SCAN_BASE:      scan_base <= cfg_data[ADDR_W-1:0];
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                     s1_valid;
  logic                     s1_cmd;
  logic [ENTRY_INDEX_W-1:0] s1_entry_index;
  logic [BYTE_W-1:0]        s1_pattern_byte;
  logic                     s1_wildcard;
  logic [BYTE_W-1:0]        s1_data_byte;
  logic                     s1_last;
  logic                     s1_fire;

  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd          <= req.cmd;
      s1_entry_index  <= req.entry_index;
      s1_pattern_byte <= req.pattern_byte;
      s1_wildcard     <= req.wildcard_req;
      s1_data_byte    <= req.data_byte;
      s1_last         <= req.last_byte;
    end
  end

  // ---------------- scan state ----------------
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   already_reported;
  logic                   s1_is_scan;
  logic                   active;      // scan byte that still counts
  logic                   hit;
  logic                   res_found;
  logic                   res_any;
  logic                   rsp_valid_q;
  logic                   out_free;
  logic [OFFSET_BITS-1:0] start_offset;
  core_ctrl_t             ctrl;

  assign s1_is_scan = (s1_cmd == CMD_SCAN);
  assign active     = s1_is_scan && !already_reported;
  assign res_found  = active && hit;
  assign res_any    = active && (hit || s1_last);
  assign out_free   = !rsp_valid_q || rsp.ready;
  assign s1_fire    = s1_valid && (!res_any || out_free);

  // Start of a match ending at this byte, modulo the offset width
  assign start_offset = OFFSET_BITS'(SUB_W'(byte_offset) - SUB_W'(lenm1));

  assign ctrl.load  = s1_fire && (s1_cmd == CMD_LOAD);
  assign ctrl.scan  = s1_fire && active;
  assign ctrl.clear = s1_fire && s1_is_scan && s1_last;

  wbps_match_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .IDX_W       (IDX_W)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .load_index (s1_entry_index),
    .load_byte  (s1_pattern_byte),
    .load_wild  (s1_wildcard),
    .data_byte  (s1_data_byte),
    .lenm1      (lenm1),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      byte_offset      <= '0;
      already_reported <= 1'b0;
    end else if (ctrl.scan) begin
      byte_offset <= byte_offset + OFFSET_BITS'(1);
      if (res_found) begin
        already_reported <= 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  logic                   rsp_found;
  logic [OFFSET_BITS-1:0] rsp_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_fire && res_any) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_any) begin
      rsp_found <= hit;
      rsp_start <= start_offset;
    end
  end

  // The user is to change scan_base only while idle (the block leaves this unchecked); then adding it here is safe
  assign rsp.valid         = rsp_valid_q;
  assign rsp.found         = rsp_found;
  assign rsp.match_address = rsp_found ?
                             (scan_base + {{(ADDR_W-OFFSET_BITS){1'b0}}, rsp_start}) : '0;

`ifndef ASSERT_OFF
  // A finished scan leaves no offset or report flag behind
  a_scan_end_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (byte_offset == '0) && !already_reported)
    else $error("scan state not cleared after last byte");

  // A match mid-buffer silences the rest of the scan
  a_report_sticks: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_found && !s1_last) |=> already_reported)
    else $error("report flag not set after match");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && rsp_valid_q && !rsp.ready))
    else $error("input stalled without a pending result");

  // A result enters only an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid_q && !rsp.ready) |=> $stable(rsp_found) && $stable(rsp_start))
    else $error("pending result overwritten");
`endif

endmodule

[verif/wildcard_byte_pattern_scanner_test.sv]
// Self-checking testbench for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_test;
  import wbps_pkg::*;

  localparam int PAT_MAX     = PATTERN_MAX_DEFAULT;
  localparam int OFF_BITS    = OFFSET_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;
  // A scan byte with no report can still be in flight when the last report
  // has come, so give it some margin before a cfg write.
  localparam int SETTLE_CYCLES = 6;

  // One request transaction, plus the idle cycles the driver waits before it.
  typedef struct packed {
    cmd_t                     cmd;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [BYTE_W-1:0]        pattern_byte;
    logic                     wildcard_req;
    logic [BYTE_W-1:0]        data_byte;
    logic                     last_byte;
    logic [3:0]               gap;
  } scan_req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } scan_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  wbps_req_if req_ch ();
  wbps_rsp_if rsp_ch ();

  wildcard_byte_pattern_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // Stimulus and expectations
  scan_req_t    req_pending[$];      // filled by the initial block, drained by the driver
  scan_report_t awaited_reports[$];  // predicted reports, oldest first
  int           items_outstanding = 0;  // pushed but not yet accepted
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           src_burst = 1'b0;
  bit           snk_burst = 1'b0;

  // Predictor state: its own copy of the pattern, match vector and registers
  logic [BYTE_W-1:0]   exp_pat  [PAT_MAX];
  logic                exp_wild [PAT_MAX];
  logic [PAT_MAX-1:0]  live_prefix = '0;   // bit j: positions 0..j match ending here
  logic [OFF_BITS-1:0] next_offset = '0;
  logic                report_done = 1'b0;
  logic [7:0]          cfg_len = 8'd1;
  logic [ADDR_W-1:0]   cfg_base = '0;

  // Generator's view of the loaded pattern, used to plant occurrences
  logic [BYTE_W-1:0] tgt_pat  [PAT_MAX];
  logic              tgt_wild [PAT_MAX];

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Zero acts as one, anything above the store depth saturates.
  function automatic int eff_len(input logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > PAT_MAX) return PAT_MAX;
    return int'(v);
  endfunction

  // Advance the predictor by one accepted transaction.
  function automatic void step_matcher(input scan_req_t it);
    logic [PAT_MAX-1:0]  hit;
    logic [OFF_BITS-1:0] start_off;
    int                  len;
    scan_report_t        rep;
    if (it.cmd == CMD_LOAD) begin
      exp_pat[it.entry_index]  = it.pattern_byte;
      exp_wild[it.entry_index] = it.wildcard_req;
    end else begin
      if (!report_done) begin
        len = eff_len(cfg_len);
        for (int k = 0; k < PAT_MAX; k++) begin
          hit[k] = exp_wild[k] | (exp_pat[k] == it.data_byte);
        end
        // shift-and: every position moves one step along the byte stream
        live_prefix = {live_prefix[PAT_MAX-2:0], 1'b1} & hit;
        if (live_prefix[len-1]) begin
          start_off = next_offset - OFF_BITS'(len - 1);
          rep.found = 1'b1;
          rep.match_address = cfg_base + {{(ADDR_W-OFF_BITS){1'b0}}, start_off};
          awaited_reports = {awaited_reports, rep};
          report_done = 1'b1;
        end else if (it.last_byte) begin
          rep.found = 1'b0;
          rep.match_address = '0;
          awaited_reports = {awaited_reports, rep};
        end
        next_offset = next_offset + 1'b1;
      end
      if (it.last_byte) begin
        live_prefix = '0;
        next_offset = '0;
        report_done = 1'b0;
      end
    end
  endfunction

  // Gap before the next request; bursts with no gaps come and go at random.
  function automatic logic [3:0] draw_gap();
    if ($urandom_range(0, 31) == 0) src_burst = ~src_burst;
    return src_burst ? 4'd0 : 4'($urandom_range(0, 15));
  endfunction

  task automatic push_load(input logic [ENTRY_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] pb,
                           input logic wild);
    scan_req_t it;
    it.cmd          = CMD_LOAD;
    it.entry_index  = idx;
    it.pattern_byte = pb;
    it.wildcard_req = wild;
    it.data_byte    = 8'($urandom);   // unused by a load
    it.last_byte    = 1'($urandom);
    it.gap          = draw_gap();
    tgt_pat[idx]    = pb;
    tgt_wild[idx]   = wild;
    items_outstanding++;
    req_pending = {req_pending, it};
  endtask

  task automatic push_scan(input logic [BYTE_W-1:0] db, input logic last);
    scan_req_t it;
    it.cmd          = CMD_SCAN;
    it.entry_index  = 7'($urandom);   // unused by a scan
    it.pattern_byte = 8'($urandom);
    it.wildcard_req = 1'($urandom);
    it.data_byte    = db;
    it.last_byte    = last;
    it.gap          = draw_gap();
    items_outstanding++;
    req_pending = {req_pending, it};
  endtask

  // Block is idle once every request is taken, every report is in, and any
  // trailing non-reporting byte has had time to leave the pipeline.
  task automatic wait_idle();
    while (items_outstanding != 0 || awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_PATTERN_LENGTH) cfg_len = val[7:0];
    else cfg_base = val;
    cfg_we <= 1'b0;
  endtask

  // One setting of the registers, a fresh pattern, then a run of buffers.
  // Most buffers carry a planted occurrence; some are pure noise and some
  // carry an occurrence with one byte corrupted.
  task automatic run_phase(input logic [7:0] len_val, input logic [ADDR_W-1:0] base_val,
                           input int scans);
    logic [63:0]       upper;
    logic [BYTE_W-1:0] b;
    int                eff;
    int                buf_len;
    int                at;
    int                broken_pos;
    bit                embed;
    upper = {$urandom(), $urandom()};
    // upper bits of the length write are don't-care
    write_reg(REG_PATTERN_LENGTH, {upper[63:8], len_val});
    write_reg(REG_SCAN_BASE, base_val);
    eff = eff_len(len_val);
    for (int i = 0; i < eff; i++) begin
      push_load(7'(i), 8'($urandom), $urandom_range(0, 4) == 0);
    end
    for (int s = 0; s < scans; s++) begin
      embed      = $urandom_range(0, 3) != 0;
      buf_len    = embed ? eff + $urandom_range(0, 8) : $urandom_range(1, eff + 8);
      at         = embed ? $urandom_range(0, buf_len - eff) : -1;
      broken_pos = (embed && $urandom_range(0, 7) == 0) ? at + $urandom_range(0, eff - 1) : -1;
      for (int i = 0; i < buf_len; i++) begin
        // occasional pattern rewrite in the middle of a buffer
        if ($urandom_range(0, 23) == 0) begin
          push_load(7'($urandom), 8'($urandom), $urandom_range(0, 4) == 0);
        end
        if (embed && i >= at && i < at + eff) begin
          b = tgt_wild[i-at] ? 8'($urandom) : tgt_pat[i-at];
        end else if ($urandom_range(0, 2) == 0) begin
          b = tgt_pat[$urandom_range(0, eff - 1)];   // near-miss noise
        end else begin
          b = 8'($urandom);
        end
        if (i == broken_pos) b = ~b;
        push_scan(b, i == buf_len - 1);
      end
    end
  endtask

  // Driver: presents queued transactions, honoring each one's idle gap.
  scan_req_t shown_item;
  int        gap_waited = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_waited = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_matcher(shown_item);
        items_outstanding--;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_pending.size() != 0 && gap_waited >= req_pending[0].gap) begin
          shown_item = req_pending.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.cmd          <= shown_item.cmd;
          req_ch.entry_index  <= shown_item.entry_index;
          req_ch.pattern_byte <= shown_item.pattern_byte;
          req_ch.wildcard_req <= shown_item.wildcard_req;
          req_ch.data_byte    <= shown_item.data_byte;
          req_ch.last_byte    <= shown_item.last_byte;
          gap_waited = 0;
        end else begin
          req_ch.valid <= 1'b0;
          if (req_pending.size() != 0) gap_waited++;
        end
      end
    end
  end

  // Monitor: checks each report against the oldest prediction and after each
  // one may hold ready low for a random stretch, except during sink bursts.
  int           hold_left = 0;
  scan_report_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = $urandom_range(0, 15);
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_reports.size() == 0) begin
          note_mismatch($sformatf("report with none pending: found=%0b addr=%h",
                                  rsp_ch.found, rsp_ch.match_address));
        end else begin
          want = awaited_reports.pop_front();
          if (rsp_ch.found !== want.found) begin
            note_mismatch($sformatf("found %0b, predicted %0b", rsp_ch.found, want.found));
          end
          if (rsp_ch.match_address !== want.match_address) begin
            note_mismatch($sformatf("match_address %h, predicted %h",
                                    rsp_ch.match_address, want.match_address));
          end
        end
        if ($urandom_range(0, 7) == 0) snk_burst = ~snk_burst;
        hold_left = snk_burst ? 0 : $urandom_range(0, 15);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_ch.ready <= (hold_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wildcard_byte_pattern_scanner verification failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_LOAD;
    req_ch.entry_index  = '0;
    req_ch.pattern_byte = '0;
    req_ch.wildcard_req = 1'b0;
    req_ch.data_byte    = '0;
    req_ch.last_byte    = 1'b0;
    rsp_ch.ready        = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole store first so no scan ever reads an unwritten entry.
    for (int i = 0; i < PAT_MAX; i++) begin
      push_load(7'(i), 8'($urandom), $urandom_range(0, 3) == 0);
    end

    // Directed, with reset registers (length 1, base 0).
    push_load(0, 8'hFF, 1'b0);
    push_scan(8'h00, 1'b0);
    push_scan(8'hFF, 1'b0);       // match at offset 1
    push_scan(8'h12, 1'b0);       // swallowed after the report
    push_scan(8'h34, 1'b1);       // swallowed last byte ends the scan silently
    push_scan(8'h00, 1'b1);       // one-byte buffer, no match
    push_scan(8'hFF, 1'b1);       // match on the final byte
    push_load(0, 8'h00, 1'b1);
    push_scan(8'h55, 1'b1);       // wildcard matches anything

    // Three-entry pattern with a wildcard in the middle; base near the top so
    // the report address wraps.
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_SCAN_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
    push_load(0, 8'hAB, 1'b0);
    push_load(1, 8'h00, 1'b1);
    push_load(2, 8'h00, 1'b0);
    push_scan(8'hAB, 1'b1);       // buffer shorter than the pattern
    push_scan(8'hAB, 1'b0);
    push_scan(8'h11, 1'b0);
    push_load(2, 8'h77, 1'b0);    // load in mid-scan, seen by the next byte
    push_scan(8'h77, 1'b0);
    push_scan(8'h00, 1'b1);
    push_scan(8'h01, 1'b0);
    push_scan(8'hAB, 1'b0);
    push_scan(8'hAB, 1'b0);
    push_scan(8'h99, 1'b0);
    push_scan(8'h77, 1'b1);       // match at start 2 on the final byte, address wraps

    // Random phases: zero and oversize lengths, both base extremes.
    run_phase(8'd2, {$urandom(), $urandom()}, 4);
    run_phase(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 6);
    run_phase(8'd255, {$urandom(), $urandom()}, 1);   // saturates to full depth
    run_phase(8'd5, 64'd0, 4);
    run_phase(8'd1, {$urandom(), $urandom()}, 4);
    for (int p = 0; p < 1; p++) begin
      run_phase(8'($urandom_range(3, 12)), {$urandom(), $urandom()}, 5);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("wildcard_byte_pattern_scanner verification clean");
    end else begin
      $display("wildcard_byte_pattern_scanner verification failed");
    end
    $finish;
  end

endmodule
